/* rtl/core/lifo_pkg.sv */
// ----------------------------------------------------------------------------
// lifo_pkg
// Shared request codes and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package lifo_pkg;

	typedef enum logic [1:0] {
		REQ_PUSH = 2'd0,
		REQ_POP  = 2'd1,
		REQ_PEEK = 2'd2,
		REQ_FIND = 2'd3
	} req_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;     // latch request, clear result flags
		logic push_wr;    // write value on top, count up
		logic pop_dec;    // count down
		logic rd_top;     // read the top entry
		logic scan_step;  // move scan one entry down
		logic set_ok;     // mark request as successful
		logic load_out;   // move result into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic full;
		logic match;      // scanned entry equals search value
		logic last;       // scanned entry is the bottom one
		logic out_free;   // output register can take a result
	} status_t;

endpackage

/* rtl/core/lifo_stack_with_search.sv */
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// Last-in first-out store of 32-bit words with push, pop, peek and find.
// ----------------------------------------------------------------------------
// Sequencing: push, pop, peek and requests that fail on an empty or full stack
//   go straight to the result stage; find scans from the top down, one entry
//   per cycle through the single registered memory read port, until a match or
//   the bottom entry.
// Requests: a new one is taken only after the last result enters the output register.
// Reset: arst_n clears the count and output valid; memory is not cleared.
module lifo_stack_with_search #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] data_out, [37:32] found_depth,
	                               // [38] now_empty, [39] zero
	output logic [0:0]  m_tuser    // [0] ok
);
	import lifo_pkg::*;

	cmd_t    cmd;
	status_t st;

	// Sequencer decides per item which memory accesses and count updates run.
	lifo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req      (s_tuser),
		.st       (st),
		.cmd      (cmd)
	);

	// Storage, scan pointer and output register; the output register lets a
	// new item be taken while the previous result is still waiting.
	lifo_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.req      (s_tuser),
		.value    (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

/* rtl/core/lifo_ctrl.sv */
// ----------------------------------------------------------------------------
// lifo_ctrl
// Request sequencer: decodes each item and steps the datapath through it.
// ----------------------------------------------------------------------------
module lifo_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [1:0]        req,
	input  lifo_pkg::status_t st,
	output lifo_pkg::cmd_t    cmd
);
	import lifo_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	req_t   req_in;

	assign req_in   = req_t'(req);
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_FIN;
					case (req_in)
						REQ_PUSH: begin
							if (!st.full) begin
								cmd.push_wr = 1'b1;
								cmd.set_ok  = 1'b1;
							end
						end
						REQ_POP: begin
							if (!st.empty) begin
								cmd.rd_top  = 1'b1;
								cmd.pop_dec = 1'b1;
								cmd.set_ok  = 1'b1;
							end
						end
						REQ_PEEK: begin
							if (!st.empty) begin
								cmd.rd_top = 1'b1;
								cmd.set_ok = 1'b1;
							end
						end
						default: begin
							if (!st.empty) begin
								cmd.rd_top = 1'b1;
								state_d    = ST_SCAN;
							end
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (st.match) begin
					cmd.set_ok = 1'b1;
					state_d    = ST_FIN;
				end else if (st.last) begin
					state_d = ST_FIN;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_FIN: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/lifo_dp.sv */
// ----------------------------------------------------------------------------
// lifo_dp
// Stack memory, count, scan pointer, result flags and output register.
// ----------------------------------------------------------------------------
module lifo_dp #(
	parameter int DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lifo_pkg::cmd_t    cmd,
	output lifo_pkg::status_t st,
	input  logic [1:0]        req,
	input  logic [31:0]       value,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [39:0]       m_tdata,
	output logic [0:0]        m_tuser
);
	import lifo_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	logic [31:0]   mem [DEPTH];
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_m1;
	logic [AW-1:0] top_idx;
	logic [AW-1:0] scan_addr_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] dist_q;
	logic [31:0]   dist_ext;
	logic [31:0]   rd_data_q;
	logic [31:0]   value_q;
	req_t          req_q;
	logic          ok_q;
	logic          out_valid_q;
	logic [31:0]   res_data;
	logic [5:0]    res_depth;

	assign count_m1 = count_q - CW'(1);
	assign top_idx  = count_m1[AW-1:0];
	assign rd_addr  = cmd.scan_step ? (scan_addr_q - AW'(1)) : top_idx;
	assign dist_ext = 32'(dist_q);

	assign st.empty    = (count_q == '0);
	assign st.full     = (count_q == CW'(DEPTH));
	assign st.match    = (rd_data_q == value_q);
	assign st.last     = (CW'(dist_q) == count_m1);
	assign st.out_free = !out_valid_q || m_tready;

	// memory port: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.push_wr) begin
			mem[count_q[AW-1:0]] <= value;
		end
		if (cmd.rd_top || cmd.scan_step) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ok_q    <= 1'b0;
		end else begin
			if (cmd.push_wr) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop_dec) begin
				count_q <= count_m1;
			end
			if (cmd.set_ok) begin
				ok_q <= 1'b1;
			end else if (cmd.accept) begin
				ok_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q       <= req_t'(req);
			value_q     <= value;
			scan_addr_q <= top_idx;
			dist_q      <= '0;
		end else if (cmd.scan_step) begin
			scan_addr_q <= scan_addr_q - AW'(1);
			dist_q      <= dist_q + AW'(1);
		end
	end

	assign res_data  = (ok_q && (req_q == REQ_POP || req_q == REQ_PEEK)) ? rd_data_q : '0;
	assign res_depth = (ok_q && req_q == REQ_FIND) ? dist_ext[5:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_tdata <= {1'b0, st.empty, res_depth, res_data};
			m_tuser <= ok_q;
		end
	end

	assign m_tvalid = out_valid_q;

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_wr |-> !st.full)
		else $error("push issued on full stack");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("count above depth");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_dec |=> count_q == $past(count_q) - CW'(1))
		else $error("pop did not decrement count");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_tready))
		else $error("result overwrote pending output");
`endif

endmodule

/* tb/sv/lifo_checker.sv */
// ----------------------------------------------------------------------------
// lifo_checker
// Watches the request and result streams of the stack, predicts every result
// from its own copy of the stack and compares field by field.
// ----------------------------------------------------------------------------
module lifo_checker #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // [31:0] data_out, [37:32] found_depth,
	                               // [38] now_empty, [39] zero
	input  logic [0:0]  m_tuser,   // [0] ok
	output int          mismatches,
	output int          outstanding,
	output int          n_checked,
	output int          n_full_refused,
	output int          n_empty_failed,
	output int          deepest_hit
);
	timeunit 1ns;
	timeprecision 1ps;
	import lifo_pkg::*;

	typedef struct packed {
		logic        ok;
		logic [31:0] data_out;
		logic [5:0]  found_depth;
		logic        now_empty;
	} lifo_result_t;

	logic [31:0]  stack_mem [DEPTH];
	int           stack_count = 0;
	lifo_result_t expected_results[$];
	lifo_result_t want;
	lifo_result_t got;

	int mismatch_count = 0;
	int checked_count = 0;
	int full_refused_count = 0;
	int empty_failed_count = 0;
	int deepest_match = 0;

	assign mismatches     = mismatch_count;
	assign n_checked      = checked_count;
	assign n_full_refused = full_refused_count;
	assign n_empty_failed = empty_failed_count;
	assign deepest_hit    = deepest_match;

	// applies one request to the shadow stack and returns the result it gives
	function automatic lifo_result_t apply_request(req_t req, logic [31:0] val);
		lifo_result_t r;
		int k;
		r = '0;
		case (req)
			REQ_PUSH: begin
				if (stack_count < DEPTH) begin
					stack_mem[stack_count] = val;
					stack_count++;
					r.ok = 1'b1;
				end else begin
					full_refused_count++;
				end
			end
			REQ_POP: begin
				if (stack_count > 0) begin
					stack_count--;
					r.data_out = stack_mem[stack_count];
					r.ok = 1'b1;
				end else begin
					empty_failed_count++;
				end
			end
			REQ_PEEK: begin
				if (stack_count > 0) begin
					r.data_out = stack_mem[stack_count - 1];
					r.ok = 1'b1;
				end else begin
					empty_failed_count++;
				end
			end
			default: begin
				if (stack_count == 0)
					empty_failed_count++;
				// first match from the top wins
				for (k = 0; k < stack_count; k++) begin
					if (stack_mem[stack_count - 1 - k] == val) begin
						r.ok = 1'b1;
						r.found_depth = k[5:0];
						if (k > deepest_match)
							deepest_match = k;
						break;
					end
				end
			end
		endcase
		r.now_empty = (stack_count == 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_count = 0;
			expected_results.delete();
			outstanding <= 0;
		end else begin
			// result side first: a result never belongs to a request of the same edge
			if (m_tvalid && m_tready) begin
				got.ok          = m_tuser[0];
				got.data_out    = m_tdata[31:0];
				got.found_depth = m_tdata[37:32];
				got.now_empty   = m_tdata[38];
				checked_count++;
				if (expected_results.size() == 0) begin
					$error("result item with no request outstanding");
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (got.ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, got.ok);
						mismatch_count++;
					end
					if (got.data_out !== want.data_out) begin
						$error("data_out: expected %0d, got %0d",
							$signed(want.data_out), $signed(got.data_out));
						mismatch_count++;
					end
					if (got.found_depth !== want.found_depth) begin
						$error("found_depth: expected %0d, got %0d",
							want.found_depth, got.found_depth);
						mismatch_count++;
					end
					if (got.now_empty !== want.now_empty) begin
						$error("now_empty: expected %0d, got %0d",
							want.now_empty, got.now_empty);
						mismatch_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(apply_request(req_t'(s_tuser), s_tdata));
			outstanding <= expected_results.size();
		end
	end

endmodule

/* tb/sv/tb_lifo_stack_with_search.sv */
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_search
// Drives push, pop, peek and find requests into the stack with random gaps
// and result back-pressure; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_search;
	timeunit 1ns;
	timeprecision 1ps;
	import lifo_pkg::*;

	localparam int DEPTH        = 64;
	localparam int N_ITEMS      = 550;
	localparam int IDLE_LIMIT   = 1000;
	localparam int TAIL_CYCLES  = 80;    // covers a find over the whole stack

	// values that hit sign, all-ones and alternating bit patterns
	localparam logic [31:0] CORNER_VALS [8] = '{
		32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
		32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001
	};

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_SEARCH, MIX_EVEN} traffic_mix_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] value
	logic [1:0]  s_tuser;   // [1:0] req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [31:0] data_out, [37:32] found_depth, [38] now_empty
	logic [0:0]  m_tuser;   // [0] ok

	int mismatches;
	int outstanding;
	int n_checked;
	int n_full_refused;
	int n_empty_failed;
	int deepest_hit;

	int           items_sent = 0;
	bit           sender_gaps_on = 1'b1;
	bit           receiver_gaps_on = 1'b1;
	logic [31:0]  pushed_vals[$];   // recent push values, to aim finds at hits
	int           idle_cycles = 0;
	traffic_mix_t mix;
	int           seg_idx;
	int           seg_len;
	int           roll;
	int           push_pct, pop_pct, peek_pct;
	req_t         req;
	logic [31:0]  val;

	lifo_stack_with_search #(.DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	lifo_checker #(.DEPTH(DEPTH)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.n_checked      (n_checked),
		.n_full_refused (n_full_refused),
		.n_empty_failed (n_empty_failed),
		.deepest_hit    (deepest_hit)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one request item: optional gap, then hold valid until accepted
	task automatic send_request(req_t r, logic [31:0] v);
		int gap;
		gap = sender_gaps_on ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= r;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (r == REQ_PUSH) begin
			pushed_vals.push_back(v);
			if (pushed_vals.size() > 128)
				void'(pushed_vals.pop_front());
		end
	endtask

	// stop sending and hold off until every predicted result came back
	task automatic wait_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// result side: random stalls per item, with stretches of no stall
	initial begin : result_sink
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 29) == 0)
				receiver_gaps_on = !receiver_gaps_on;
			gap = receiver_gaps_on ? $urandom_range(0, 10) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// watchdog: no item accepted on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = REQ_PUSH;
		arst_n   = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: empty-stack failures, extremes, find order, drain ---
		send_request(REQ_POP,  32'h0000_0000);
		send_request(REQ_PEEK, 32'hFFFF_FFFF);
		send_request(REQ_FIND, 32'h0000_0000);   // find on empty
		send_request(REQ_PUSH, 32'h8000_0000);
		send_request(REQ_PUSH, 32'h7FFF_FFFF);
		send_request(REQ_PUSH, 32'h0000_0000);
		send_request(REQ_PUSH, 32'hFFFF_FFFF);
		send_request(REQ_PEEK, 32'h0000_0000);
		send_request(REQ_FIND, 32'hFFFF_FFFF);   // match at the top
		send_request(REQ_FIND, 32'h8000_0000);   // match at the bottom
		send_request(REQ_FIND, 32'h7FFF_FFFE);   // no match, one bit off
		send_request(REQ_FIND, 32'h0000_8000);   // no match
		send_request(REQ_PUSH, 32'h7FFF_FFFF);   // duplicate: nearer copy wins
		send_request(REQ_FIND, 32'h7FFF_FFFF);
		send_request(REQ_POP,  32'h0000_0000);
		send_request(REQ_FIND, 32'h7FFF_FFFF);
		send_request(REQ_POP,  32'h0000_0000);
		send_request(REQ_POP,  32'h0000_0000);
		send_request(REQ_POP,  32'h0000_0000);
		send_request(REQ_PEEK, 32'h0000_0000);
		send_request(REQ_POP,  32'h0000_0000);   // last entry leaves
		send_request(REQ_POP,  32'h0000_0000);   // pop on empty again
		send_request(REQ_FIND, 32'h8000_0000);
		wait_until_drained();

		// --- random: segments biased toward filling, draining or searching.
		// The first segment fills past full, the second searches the full stack.
		seg_idx = 0;
		while (items_sent < N_ITEMS) begin
			if (seg_idx == 0)
				mix = MIX_FILL;
			else if (seg_idx == 1)
				mix = MIX_SEARCH;
			else
				mix = traffic_mix_t'($urandom_range(0, 3));
			seg_len = (seg_idx == 0) ? 80 : $urandom_range(10, 80);
			sender_gaps_on = (seg_idx == 0) || ($urandom_range(0, 3) != 0);
			case (mix)
				MIX_FILL:   begin push_pct = 85; pop_pct = 3;  peek_pct = 4;  end
				MIX_DRAIN:  begin push_pct = 8;  pop_pct = 80; peek_pct = 4;  end
				MIX_SEARCH: begin push_pct = 25; pop_pct = 5;  peek_pct = 10; end
				default:    begin push_pct = 25; pop_pct = 25; peek_pct = 25; end
			endcase
			for (int i = 0; i < seg_len && items_sent < N_ITEMS; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < push_pct)
					req = REQ_PUSH;
				else if (roll < push_pct + pop_pct)
					req = REQ_POP;
				else if (roll < push_pct + pop_pct + peek_pct)
					req = REQ_PEEK;
				else
					req = REQ_FIND;
				roll = $urandom_range(0, 9);
				if (req == REQ_FIND && roll < 6 && pushed_vals.size() > 0)
					val = pushed_vals[$urandom_range(0, pushed_vals.size() - 1)];
				else if (roll < 8)
					val = (roll == 7) ? $urandom_range(0, 15) : $urandom;
				else
					val = CORNER_VALS[$urandom_range(0, 7)];
				send_request(req, val);
			end
			if (seg_idx == 1 || $urandom_range(0, 3) == 0)
				wait_until_drained();
			seg_idx++;
		end

		wait_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run summary: %0d request items checked, %0d pushes refused on a full stack,",
			n_checked, n_full_refused);
		$display("  %0d requests on an empty stack, deepest find hit %0d below the top.",
			n_empty_failed, deepest_hit);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/lifo_pkg.sv
rtl/core/lifo_ctrl.sv
rtl/core/lifo_dp.sv
rtl/core/lifo_stack_with_search.sv
tb/sv/lifo_checker.sv
tb/sv/tb_lifo_stack_with_search.sv
